### src/gmps_pkg.sv
// Shared types and constants for the grid minimum path sum block.
// No dependencies; imported by every module of the block but gmps_queue.
`default_nettype none

package gmps_pkg;

	// Field widths fixed by the interface
	localparam int CELL_W    = 16;
	localparam int RES_W     = 24;
	localparam int CFG_W     = 8;
	localparam int CFG_IDX_W = 1;

	// Default grid limit
	localparam int MAX_DIM_DEF = 128;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

	// Position class of one cell, worked out by the front end
	typedef struct packed {
		logic first_row;
		logic first_col;
		logic finish;
	} class_t;

endpackage : gmps_pkg

`default_nettype wire

### src/grid_min_path_sum.sv
// Top level of the grid minimum path sum block: front end, queue, back end.
// Depends on gmps_pkg, gmps_front, gmps_queue and gmps_back.
//
//   channel   direction  handshake                  payload
//   cell      in         cell_valid / cell_ready    cell_cost
//   result    out        result_valid / result_ready path_cost, is_finish
//   cfg       in         cfg_wr_en                  cfg_index, cfg_data
//
// One cell per cycle while result_ready is high; each cell passes a queue
// slot, the stage-1 registers and the output register to the result port;
// the combinational add/min/saturate on the left neighbour sets that rate.
// Reset clears position, size registers (to 1 by 1) and all valid flags; the
// row memory is not cleared and is only used after the first row wrote it.
// A stalled result holds its register; the two-entry queue and the compute
// stage keep taking cells until four are in flight, then cell_ready drops.
`default_nettype none

module grid_min_path_sum #(
	parameter int MAX_DIM = gmps_pkg::MAX_DIM_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wr_en,
	input  wire  [gmps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [gmps_pkg::CFG_W-1:0]          cfg_data,
	input  wire                                 cell_valid,
	output logic                                cell_ready,
	input  wire  signed [gmps_pkg::CELL_W-1:0]  cell_cost,
	output logic                                result_valid,
	input  wire                                 result_ready,
	output logic signed [gmps_pkg::RES_W-1:0]   path_cost,
	output logic                                is_finish
);
	import gmps_pkg::*;

	localparam int COL_W = $clog2(MAX_DIM);
	localparam int CLS_W = $bits(class_t);
	localparam int Q_W   = CELL_W + COL_W + CLS_W;

	logic              push;
	logic              full;
	logic              empty;
	logic              pop;
	logic [COL_W-1:0]  front_col;
	class_t            front_cls;
	logic [Q_W-1:0]    push_data;
	logic [Q_W-1:0]    pop_data;
	logic signed [CELL_W-1:0] q_cost;
	logic [COL_W-1:0]  q_col;
	class_t            q_cls;

	// Classify each cell by its position in the grid
	gmps_front #(
		.MAX_DIM (MAX_DIM)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_valid (cell_valid),
		.cell_ready (cell_ready),
		.q_full     (full),
		.q_push     (push),
		.q_col      (front_col),
		.q_cls      (front_cls)
	);

	// Pack cost, column and class for the queue
	assign push_data = {cell_cost, front_col, front_cls};

	gmps_queue #(
		.WIDTH (Q_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	assign q_cost = pop_data[Q_W-1 -: CELL_W];
	assign q_col  = pop_data[CLS_W +: COL_W];
	assign q_cls  = pop_data[CLS_W-1:0];

	// Compute the path sum and hold it until transfer
	gmps_back #(
		.MAX_DIM (MAX_DIM)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (!empty),
		.q_cost       (q_cost),
		.q_col        (q_col),
		.q_cls        (q_cls),
		.q_pop        (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.path_cost    (path_cost),
		.is_finish    (is_finish)
	);

endmodule : grid_min_path_sum

`default_nettype wire

### src/gmps_front.sv
// Front end: takes cells, tracks grid position and holds the grid size registers.
// Depends on gmps_pkg.
`default_nettype none

module gmps_front #(
	parameter int MAX_DIM = gmps_pkg::MAX_DIM_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_wr_en,
	input  wire  [gmps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [gmps_pkg::CFG_W-1:0]          cfg_data,
	input  wire                                 cell_valid,
	output logic                                cell_ready,
	input  wire                                 q_full,
	output logic                                q_push,
	output logic [$clog2(MAX_DIM)-1:0]          q_col,
	output gmps_pkg::class_t                    q_cls
);
	import gmps_pkg::*;

	localparam int COL_W = $clog2(MAX_DIM);
	localparam int DIM_W = $clog2(MAX_DIM + 1);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] row_q;
	logic             last_col;
	logic             last_row;

	// Zero acts as one, anything past the limit acts as the limit
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [31:0] x;
		x = 32'(v);
		if (x == 32'd0) begin
			x = 32'd1;
		end else if (x > 32'(MAX_DIM)) begin
			x = 32'(MAX_DIM);
		end
		return DIM_W'(x);
	endfunction

	assign cell_ready = !q_full;
	assign q_push     = cell_valid && cell_ready;
	assign last_col   = (DIM_W'(col_q) == width_q - DIM_W'(1));
	assign last_row   = (DIM_W'(row_q) == height_q - DIM_W'(1));
	assign q_col      = col_q;

	always_comb begin
		q_cls.first_row = (row_q == '0);
		q_cls.first_col = (col_q == '0);
		q_cls.finish    = last_row && last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1);
			height_q <= DIM_W'(1);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wr_en) begin
			// any write restarts the grid
			unique case (cfg_index)
				REG_GRID_WIDTH:  width_q  <= eff_dim(cfg_data);
				REG_GRID_HEIGHT: height_q <= eff_dim(cfg_data);
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (!last_col) begin
				col_q <= col_q + COL_W'(1);
			end else begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + COL_W'(1);
			end
		end
	end

endmodule : gmps_front

`default_nettype wire

### src/gmps_queue.sv
// Two-entry queue between front end and back end.
// Generic payload; depends on nothing.
`default_nettype none

module gmps_queue #(
	parameter int WIDTH = 8
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire [WIDTH-1:0]  push_data,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);
	logic [WIDTH-1:0] slot_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full     = (count_q == 2'd2);
	assign empty    = (count_q == 2'd0);
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule : gmps_queue

`default_nettype wire

### src/gmps_back.sv
// Back end: row memory, neighbour registers, add/min/saturate and output register.
// Depends on gmps_pkg.
`default_nettype none

module gmps_back #(
	parameter int MAX_DIM = gmps_pkg::MAX_DIM_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  q_valid,
	input  wire signed [gmps_pkg::CELL_W-1:0]    q_cost,
	input  wire        [$clog2(MAX_DIM)-1:0]     q_col,
	input  wire gmps_pkg::class_t                q_cls,
	output logic                                 q_pop,
	output logic                                 result_valid,
	input  wire                                  result_ready,
	output logic signed [gmps_pkg::RES_W-1:0]    path_cost,
	output logic                                 is_finish
);
	import gmps_pkg::*;

	localparam int COL_W = $clog2(MAX_DIM);

	logic [RES_W-1:0] row_mem [MAX_DIM];

	logic                    valid_s1;
	logic signed [CELL_W-1:0] cost_s1;
	logic [COL_W-1:0]        col_s1;
	class_t                  cls_s1;
	logic signed [RES_W-1:0] up_rd_s1;
	logic                    fwd_s1;

	logic signed [RES_W-1:0] left_q;
	logic signed [RES_W-1:0] diag_q;
	logic signed [RES_W-1:0] pc_q;
	logic                    fin_q;
	logic                    ov_q;

	logic                    adv_s1;
	logic signed [RES_W-1:0] up;
	logic signed [RES_W-1:0] min_ud;
	logic signed [RES_W-1:0] min_all;
	logic signed [RES_W-1:0] base;
	logic signed [RES_W:0]   sum;
	logic signed [RES_W-1:0] res;

	assign adv_s1 = valid_s1 && (!ov_q || result_ready);
	assign q_pop  = q_valid && (!valid_s1 || adv_s1);

	// The entry written as this cell was read is the one just produced
	assign up = fwd_s1 ? left_q : up_rd_s1;

	always_comb begin
		min_ud  = (up < diag_q) ? up : diag_q;
		min_all = (left_q < min_ud) ? left_q : min_ud;
		priority if (cls_s1.first_row && cls_s1.first_col) begin
			base = '0;
		end else if (cls_s1.first_row) begin
			base = left_q;
		end else if (cls_s1.first_col) begin
			base = up;
		end else begin
			base = min_all;
		end
		sum = (RES_W+1)'(base) + (RES_W+1)'(cost_s1);
		if (sum[RES_W] != sum[RES_W-1]) begin
			res = {sum[RES_W], {(RES_W-1){!sum[RES_W]}}};
		end else begin
			res = sum[RES_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			row_mem[col_s1] <= res;
		end
		if (q_pop) begin
			up_rd_s1 <= row_mem[q_col];
			cost_s1  <= q_cost;
			col_s1   <= q_col;
			cls_s1   <= q_cls;
		end
		if (adv_s1) begin
			pc_q  <= res;
			fin_q <= cls_s1.finish;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fwd_s1   <= 1'b0;
			ov_q     <= 1'b0;
			left_q   <= '0;
			diag_q   <= '0;
		end else begin
			if (q_pop) begin
				valid_s1 <= 1'b1;
				fwd_s1   <= adv_s1 && (col_s1 == q_col);
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				left_q <= res;
				diag_q <= up;
				ov_q   <= 1'b1;
			end else if (result_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign result_valid = ov_q;
	assign path_cost    = pc_q;
	assign is_finish    = fin_q;

endmodule : gmps_back

`default_nettype wire

### src/gmps_checker.sv
// Port-level checks for grid_min_path_sum, bound to the top level.
// Depends on gmps_pkg.
`default_nettype none

module gmps_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                cell_valid,
	input wire                                cell_ready,
	input wire                                result_valid,
	input wire                                result_ready,
	input wire signed [gmps_pkg::RES_W-1:0]   path_cost,
	input wire                                is_finish
);
	import gmps_pkg::*;

	logic [2:0] pending_q;
	logic       cell_xfer;
	logic       res_xfer;

	assign cell_xfer = cell_valid && cell_ready;
	assign res_xfer  = result_valid && result_ready;

	// Track cells taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 3'd0;
		end else begin
			pending_q <= pending_q + 3'(cell_xfer) - 3'(res_xfer);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(path_cost) && $stable(is_finish))
		else $error("stalled result changed");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 3'd0)
		else $error("result without a pending cell");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("more cells in flight than storage");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd4 |-> !cell_ready)
		else $error("cell taken with all storage full");

endmodule : gmps_checker

bind grid_min_path_sum gmps_checker u_gmps_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cell_valid   (cell_valid),
	.cell_ready   (cell_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.path_cost    (path_cost),
	.is_finish    (is_finish)
);

`default_nettype wire

### sim/gmps_path_sb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the grid minimum path sum block: cell-by-cell predictor and result check.
// Depends on gmps_pkg for field widths, register indexes and the grid limit.

package gmps_path_sb_pkg;
	import gmps_pkg::*;

	localparam int DIM_LIMIT    = MAX_DIM_DEF;
	localparam int PATH_MAX     = 8388607;
	localparam int PATH_MIN     = -8388608;
	localparam int REPORT_LIMIT = 10;

	// Size register value to grid dimension in use
	function automatic int grid_extent(input logic [CFG_W-1:0] v);
		if (v == '0)
			return 1;
		if (int'(v) > DIM_LIMIT)
			return DIM_LIMIT;
		return int'(v);
	endfunction

	function automatic int lesser(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	class path_scoreboard;
		typedef struct {
			logic signed [RES_W-1:0] path;
			logic                    finish;
		} path_item_t;

		path_item_t              waiting[$];
		logic signed [RES_W-1:0] row_mem[DIM_LIMIT];
		logic signed [RES_W-1:0] left_val;
		logic signed [RES_W-1:0] diag_val;
		int                      col_pos;
		int                      row_pos;
		logic [CFG_W-1:0]        width_reg;
		logic [CFG_W-1:0]        height_reg;
		int                      failures;
		int                      cells_seen;
		int                      results_seen;
		int                      finishes;
		int                      path_lo;
		int                      path_hi;

		function new();
			foreach (row_mem[i])
				row_mem[i] = '0;
			left_val     = '0;
			diag_val     = '0;
			col_pos      = 0;
			row_pos      = 0;
			width_reg    = 8'd1;
			height_reg   = 8'd1;
			failures     = 0;
			cells_seen   = 0;
			results_seen = 0;
			finishes     = 0;
			path_lo      = PATH_MAX;
			path_hi      = PATH_MIN;
		endfunction

		// Any size write restarts the grid at the origin
		function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
			if (idx == REG_GRID_WIDTH)
				width_reg = data;
			else
				height_reg = data;
			col_pos  = 0;
			row_pos  = 0;
			left_val = '0;
			diag_val = '0;
		endfunction

		// Work out the path sum of one accepted cell and queue it
		function void note_cell(input logic signed [CELL_W-1:0] cost);
			int         w;
			int         h;
			int         c;
			int         r;
			int         up;
			int         v;
			bit         fin;
			path_item_t item;
			w = grid_extent(width_reg);
			h = grid_extent(height_reg);
			c = col_pos;
			r = row_pos;
			if (c >= w || r >= h) begin
				c = 0;
				r = 0;
			end
			up = row_mem[c];
			if (r == 0 && c == 0)
				v = cost;
			else if (r == 0)
				v = left_val + cost;
			else if (c == 0)
				v = up + cost;
			else
				v = cost + lesser(left_val, lesser(up, diag_val));
			if (v > PATH_MAX)
				v = PATH_MAX;
			else if (v < PATH_MIN)
				v = PATH_MIN;
			diag_val   = up[RES_W-1:0];
			row_mem[c] = v[RES_W-1:0];
			left_val   = v[RES_W-1:0];
			fin = (r == h - 1) && (c == w - 1);
			if (c + 1 < w) begin
				c++;
			end else begin
				c = 0;
				r = (r + 1 < h) ? r + 1 : 0;
			end
			if (fin) begin
				c = 0;
				r = 0;
			end
			col_pos     = c;
			row_pos     = r;
			item.path   = v[RES_W-1:0];
			item.finish = fin;
			waiting.push_back(item);
			cells_seen++;
		endfunction

		function void flag(input string msg);
			failures++;
			if (failures <= REPORT_LIMIT)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endfunction

		// Compare one result against the oldest expectation
		function void check_result(input logic signed [RES_W-1:0] got_path, input logic got_fin);
			path_item_t want;
			results_seen++;
			if (got_fin === 1'b1)
				finishes++;
			if (int'(got_path) < path_lo)
				path_lo = got_path;
			if (int'(got_path) > path_hi)
				path_hi = got_path;
			if (waiting.size() == 0) begin
				flag($sformatf("result path_cost=%0d is_finish=%b with none expected",
					got_path, got_fin));
				return;
			end
			want = waiting.pop_front();
			if (want.path !== got_path || want.finish !== got_fin)
				flag($sformatf("result %0d: path_cost exp %0d got %0d, is_finish exp %b got %b",
					results_seen, want.path, got_path, want.finish, got_fin));
		endfunction

		function int pending();
			return waiting.size();
		endfunction

		function void close_out();
			if (waiting.size() != 0) begin
				failures += waiting.size();
				$display("%0d expected results never arrived", waiting.size());
			end
		endfunction
	endclass

endpackage : gmps_path_sb_pkg

### sim/tb_grid_min_path_sum.sv
`timescale 1ns / 100ps
// Testbench top for grid_min_path_sum: directed and random grids under random back-pressure.
// Depends on gmps_pkg, gmps_path_sb_pkg and the grid_min_path_sum RTL.

module tb_grid_min_path_sum;
	import gmps_pkg::*;
	import gmps_path_sb_pkg::*;

	localparam int HALF_NS      = 6;
	localparam int RESET_CYCLES = 9;
	localparam int IDLE_LIMIT   = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int CELL_TARGET  = 1100;
	localparam int TAIL_CYCLES  = 20;
	localparam int GRID_CAP     = 300;

	typedef enum {COST_FULL, COST_SMALL, COST_NEG, COST_EXT} cost_mode_t;

	logic                     clk;
	logic                     arst_n;
	logic                     cfg_wr_en;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [CFG_W-1:0]         cfg_data;
	logic                     cell_valid;
	logic                     cell_ready;
	logic signed [CELL_W-1:0] cell_cost;
	logic                     result_valid;
	logic                     result_ready;
	logic signed [RES_W-1:0]  path_cost;
	logic                     is_finish;

	path_scoreboard sb;

	// Shared between the sender, the receiver and the monitor
	bit               quiet;
	bit               hold_req;
	int               hold_left;
	int               rx_stall;
	int               idle_cycles;
	int               stall_cycles;
	int               max_w;
	int               max_h;
	logic [CFG_W-1:0] cur_w;
	logic [CFG_W-1:0] cur_h;

	grid_min_path_sum uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cell_valid   (cell_valid),
		.cell_ready   (cell_ready),
		.cell_cost    (cell_cost),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.path_cost    (path_cost),
		.is_finish    (is_finish)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_NS clk = ~clk;
	end

	// Mostly back-to-back, some short gaps, a few long ones
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 70)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [CELL_W-1:0] pick_cost(input cost_mode_t mode);
		int t;
		case (mode)
			COST_FULL: begin
				t = $urandom_range(0, 65535);
			end
			COST_SMALL: begin
				t = $urandom_range(0, 200) - 100;
			end
			COST_NEG: begin
				t = -$urandom_range(20000, 32768);
			end
			default: begin
				case ($urandom_range(0, 4))
					0: t = 32767;
					1: t = -32768;
					2: t = 0;
					3: t = -1;
					default: t = $urandom_range(0, 65535);
				endcase
			end
		endcase
		return t[CELL_W-1:0];
	endfunction

	// Size register value: small sizes dominate, zero and oversize show up now and then
	function automatic logic [CFG_W-1:0] pick_dim();
		int p;
		p = $urandom_range(0, 99);
		if (p < 10)
			return '0;
		if (p < 78)
			return CFG_W'($urandom_range(1, 5));
		if (p < 90)
			return CFG_W'($urandom_range(6, 12));
		if (p < 95)
			return CFG_W'(DIM_LIMIT);
		return CFG_W'($urandom_range(DIM_LIMIT + 1, 255));
	endfunction

	// Offer one cell after a random gap and hold it until the transfer
	task automatic send_cell(input logic signed [CELL_W-1:0] cost);
		int gap;
		gap = quiet ? 0 : pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cell_valid <= 1'b1;
		cell_cost  <= cost;
		@(posedge clk);
		while (!cell_ready)
			@(posedge clk);
		sb.note_cell(cost);
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain();
		@(negedge clk);
		cell_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
	endtask

	// Write one or both size registers while the block is idle
	task automatic set_dims(input bit do_w, input bit do_h, input logic [CFG_W-1:0] w,
			input logic [CFG_W-1:0] h, input bit h_first);
		drain();
		if (do_h && h_first)
			cfg_write(REG_GRID_HEIGHT, h);
		if (do_w)
			cfg_write(REG_GRID_WIDTH, w);
		if (do_h && !h_first)
			cfg_write(REG_GRID_HEIGHT, h);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (do_w)
			cur_w = w;
		if (do_h)
			cur_h = h;
		if (grid_extent(cur_w) > max_w)
			max_w = grid_extent(cur_w);
		if (grid_extent(cur_h) > max_h)
			max_h = grid_extent(cur_h);
	endtask

	// Stream n cells; optionally ask for a long receiver hold or a full drain on the way
	task automatic run_cells(input int n, input cost_mode_t mode, input bit q,
			input int hold_at, input int pause_at);
		@(posedge clk);
		quiet = q;
		for (int i = 0; i < n; i++) begin
			if (i == pause_at)
				drain();
			send_cell(pick_cost(mode));
			if (i == hold_at)
				hold_req = 1'b1;
		end
	endtask

	// Receiver: random stalls, plus a long hold when the sender asks for one
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready <= 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 5) == 0)
					rx_stall = pick_gap();
			end
		end
	end

	// Monitor and watchdog: sample pre-edge values at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(path_cost, is_finish);
			if (cell_valid && !cell_ready)
				stall_cycles++;
			if ((cell_valid && cell_ready) || (result_valid && result_ready) || cfg_wr_en)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog: %0d cycles without a transfer, %0d results outstanding",
					idle_cycles, sb.pending());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		int               phase;
		int               cells;
		int               n;
		int               sel;
		int               hold_at;
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] h;
		cost_mode_t       mode;

		sb           = new();
		arst_n       = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		cell_valid   = 1'b0;
		cell_cost    = '0;
		result_ready = 1'b0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		hold_left    = 0;
		rx_stall     = 0;
		idle_cycles  = 0;
		stall_cycles = 0;
		cur_w        = 8'd1;
		cur_h        = 8'd1;
		max_w        = 1;
		max_h        = 1;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Reset size is 1 by 1: every cell is origin and finish, then wraps
		send_cell(32767);
		send_cell(-32768);
		send_cell(0);
		send_cell(-1);

		// Zero sizes act as one
		set_dims(1'b1, 1'b1, 8'd0, 8'd0, 1'b0);
		send_cell(16'sh5555);
		send_cell(16'shAAAA);

		// One full 3x3 grid with field extremes, then restart mid-grid by a width write
		set_dims(1'b1, 1'b1, 8'd3, 8'd3, 1'b1);
		send_cell(100);
		send_cell(-32768);
		send_cell(32767);
		send_cell(32767);
		send_cell(-5);
		send_cell(7);
		send_cell(-32768);
		send_cell(1);
		send_cell(32767);
		send_cell(3);
		send_cell(-4);
		set_dims(1'b1, 1'b0, 8'd2, 8'd0, 1'b0);
		send_cell(10);
		send_cell(-20);
		send_cell(30);
		send_cell(-40);
		send_cell(50);
		send_cell(-60);

		// Oversize width clamps to the full row; a long receiver hold fills the block
		set_dims(1'b1, 1'b1, 8'd255, 8'd2, 1'b0);
		run_cells(2 * DIM_LIMIT, COST_NEG, 1'b0, 20, -1);

		// Single column at full height; the sender pauses halfway until all results are in
		set_dims(1'b1, 1'b1, 8'd1, 8'd200, 1'b1);
		run_cells(DIM_LIMIT, COST_EXT, 1'b0, -1, DIM_LIMIT / 2);

		// Random grids: mostly whole grids, some cut short by the next size write
		phase = 0;
		while (sb.cells_seen < CELL_TARGET) begin
			w   = pick_dim();
			h   = pick_dim();
			sel = $urandom_range(0, 3);
			if (sel == 0)
				cells = grid_extent(w) * grid_extent(cur_h);
			else if (sel == 1)
				cells = grid_extent(cur_w) * grid_extent(h);
			else
				cells = grid_extent(w) * grid_extent(h);
			if (cells > GRID_CAP) begin
				sel   = 2;
				h     = CFG_W'($urandom_range(1, 2));
				cells = grid_extent(w) * grid_extent(h);
			end
			set_dims(sel != 1, sel != 0, w, h, $urandom_range(0, 1));
			n = (cells <= 40) ? cells * $urandom_range(1, 3) : cells;
			if ($urandom_range(0, 2) == 0)
				n += $urandom_range(0, cells - 1);
			hold_at = -1;
			if (phase == 5) begin
				if (n < 60)
					n = 60;
				hold_at = 10;
			end
			mode = cost_mode_t'($urandom_range(0, 3));
			run_cells(n, mode, $urandom_range(0, 4) == 0, hold_at, -1);
			phase++;
		end

		// Collect the tail, then give the block time to show any stray result
		drain();
		quiet = 1'b0;
		repeat (TAIL_CYCLES) @(negedge clk);
		sb.close_out();

		$display("Covered %0d cells over %0d size settings, %0d finished grids, up to %0d x %0d.",
			sb.cells_seen, phase + 5, sb.finishes, max_w, max_h);
		$display("Path sums ranged %0d to %0d; cell input was back-pressured for %0d cycles.",
			sb.path_lo, sb.path_hi, stall_cycles);
		if (sb.failures == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d failures", sb.failures);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule : tb_grid_min_path_sum

### sim.f
src/gmps_pkg.sv
src/gmps_front.sv
src/gmps_queue.sv
src/gmps_back.sv
src/grid_min_path_sum.sv
src/gmps_checker.sv
sim/gmps_path_sb_pkg.sv
sim/tb_grid_min_path_sum.sv
